// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the flanger core files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FL_ASSERT(lbl, clk, rstn, prop, msg)
`define FL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/flanger_pkg.sv =====
// ----------------------------------------------------------------------------
// flanger_pkg
// shared constants, types and helpers of the flanger core
// ----------------------------------------------------------------------------
package flanger_pkg;

    localparam int MAX_DELAY    = 64;
    localparam int CHANNELS     = 2;
    localparam int SINE_ENTRIES = 1024;

    localparam int PTR_W  = $clog2(MAX_DELAY);
    localparam int CH_W   = $clog2(CHANNELS);
    localparam int ADDR_W = PTR_W + CH_W;
    localparam int DEPTH  = MAX_DELAY * CHANNELS;
    localparam int K_W    = $clog2(SINE_ENTRIES);
    localparam int SMP_W  = 24;
    localparam int OP_W   = 33;
    localparam int POS_W  = PTR_W + 18;

    localparam logic signed [63:0] SIN_C1 = 64'sd1686629713;
    localparam logic signed [63:0] SIN_C3 = 64'sd693598670;
    localparam logic signed [63:0] SIN_C5 = 64'sd85569307;
    localparam logic signed [OP_W-1:0] SIN_C7 = 33'sd5026993;

    localparam logic [1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [1:0] REG_DELAY_SPAN = 2'd1;
    localparam logic [1:0] REG_FEEDBACK   = 2'd2;
    localparam logic [1:0] REG_WET_MIX    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_U2, ST_R5, ST_R3, ST_R1, ST_Y, ST_DLY, ST_RDA, ST_RDB,
        ST_INTA, ST_INTB, ST_FB, ST_MX1, ST_MX2
    } fl_state_t;

    function automatic logic signed [SMP_W-1:0] sat24(input logic signed [63:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > 64'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -64'sd8388608)
            r = 24'sh800000;
        else
            r = v[SMP_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/fl_ram.sv =====
// ----------------------------------------------------------------------------
// fl_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module fl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[addr] <= wdata;
        rdata <= mem_reg[addr];
    end

endmodule

// ===== rtl/core/fl_mul.sv =====
// ----------------------------------------------------------------------------
// fl_mul
// shared signed multiplier used by every arithmetic step of the sequencer
// ----------------------------------------------------------------------------
module fl_mul (
    input  logic signed [flanger_pkg::OP_W-1:0]   a,
    input  logic signed [flanger_pkg::OP_W-1:0]   b,
    output logic signed [2*flanger_pkg::OP_W-1:0] p
);

    assign p = a * b;

endmodule

// ===== rtl/core/flanger_fractional_delay.sv =====
// ----------------------------------------------------------------------------
// flanger_fractional_delay
// two-channel flanger: sine lfo, interpolated delay line, feedback, dry/wet mix
// ----------------------------------------------------------------------------
// Each input item steps through U2, R5, R3, R1, Y, DLY, RDA, RDB, INTA, INTB,
// FB, MX1 and MX2 to its result in the output register; the block takes one
// item at a time, and MX2 waits until the output register is free. A single
// shared 33x33 multiplier evaluates the sine polynomial, the delay, both
// interpolation taps, the feedback and the mix in turn, and the single port of
// the delay memory reads two taps and writes one per item. A finished result
// waits in the output register while the next item starts. There is no
// clearing pass after reset: per-entry valid bits stand in.
module flanger_fractional_delay (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // sample_in [23:0]
    input  logic        s_tuser,    // channel [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // sample_out [23:0]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

`include "assert_macros.svh"

    localparam int PW = flanger_pkg::PTR_W;
    localparam int OW = flanger_pkg::OP_W;
    localparam int POS_W_T = flanger_pkg::POS_W;

    flanger_pkg::fl_state_t state_reg, state_next;

    logic [23:0] phase_step_reg;
    logic [15:0] delay_span_reg;
    logic [14:0] feedback_reg;
    logic [15:0] wet_mix_reg;

    logic [31:0] phase_reg [flanger_pkg::CHANNELS];
    logic [PW-1:0] wi_reg  [flanger_pkg::CHANNELS];
    logic [flanger_pkg::DEPTH-1:0] valid_reg;
    logic rvalid_reg;

    logic [flanger_pkg::CH_W-1:0] ch_reg;
    logic signed [23:0] x_reg;
    logic [1:0]  quad_reg;
    logic [30:0] u_reg;
    logic [30:0] u2_reg;
    logic signed [31:0] r_reg;
    logic [24:0] h_reg;
    logic [PW-1:0] idx_reg;
    logic [15:0] frac_reg;
    logic signed [23:0] a_reg, b_reg, delayed_reg;
    logic signed [63:0] acc_reg;
    logic signed [23:0] back_reg;
    logic signed [23:0] out_reg;
    logic out_valid_reg;

    logic signed [OW-1:0] op_a, op_b;
    logic signed [2*OW-1:0] mul_p;
    logic signed [63:0] prod;
    logic [flanger_pkg::ADDR_W-1:0] ram_addr;
    logic ram_we;
    logic [23:0] ram_rdata;
    logic signed [23:0] tap;
    logic [PW-1:0] wi_cur;
    logic accept, finish;

    assign prod     = mul_p[63:0];
    assign wi_cur   = wi_reg[ch_reg];
    assign tap      = rvalid_reg ? signed'(ram_rdata) : 24'sd0;
    assign s_tready = (state_reg == flanger_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign finish   = (state_reg == flanger_pkg::ST_MX2) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    fl_mul u_mul (
        .a (op_a),
        .b (op_b),
        .p (mul_p)
    );

    fl_ram #(
        .WIDTH (flanger_pkg::SMP_W),
        .DEPTH (flanger_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (back_reg),
        .rdata (ram_rdata)
    );

    // operand selection, memory port and next state per step
    always_comb
    begin
        op_a     = '0;
        op_b     = '0;
        ram_we   = 1'b0;
        ram_addr = {ch_reg, wi_cur};
        state_next = state_reg;
        case (state_reg)
            flanger_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = flanger_pkg::ST_U2;
            end
            flanger_pkg::ST_U2:
            begin
                op_a = signed'({2'b0, u_reg});
                op_b = signed'({2'b0, u_reg});
                state_next = flanger_pkg::ST_R5;
            end
            flanger_pkg::ST_R5:
            begin
                op_a = signed'({2'b0, u2_reg});
                op_b = flanger_pkg::SIN_C7;
                state_next = flanger_pkg::ST_R3;
            end
            flanger_pkg::ST_R3:
            begin
                op_a = signed'({2'b0, u2_reg});
                op_b = OW'(r_reg);
                state_next = flanger_pkg::ST_R1;
            end
            flanger_pkg::ST_R1:
            begin
                op_a = signed'({2'b0, u2_reg});
                op_b = OW'(r_reg);
                state_next = flanger_pkg::ST_Y;
            end
            flanger_pkg::ST_Y:
            begin
                op_a = signed'({2'b0, u_reg});
                op_b = OW'(r_reg);
                state_next = flanger_pkg::ST_DLY;
            end
            flanger_pkg::ST_DLY:
            begin
                op_a = signed'({17'b0, delay_span_reg});
                op_b = signed'({8'b0, h_reg});
                state_next = flanger_pkg::ST_RDA;
            end
            flanger_pkg::ST_RDA:
            begin
                ram_addr = {ch_reg, idx_reg};
                state_next = flanger_pkg::ST_RDB;
            end
            flanger_pkg::ST_RDB:
            begin
                ram_addr = {ch_reg, idx_reg + PW'(1)};
                state_next = flanger_pkg::ST_INTA;
            end
            flanger_pkg::ST_INTA:
            begin
                op_a = OW'(a_reg);
                op_b = signed'(OW'(17'h10000 - {1'b0, frac_reg}));
                state_next = flanger_pkg::ST_INTB;
            end
            flanger_pkg::ST_INTB:
            begin
                op_a = OW'(b_reg);
                op_b = signed'({17'b0, frac_reg});
                state_next = flanger_pkg::ST_FB;
            end
            flanger_pkg::ST_FB:
            begin
                op_a = OW'(delayed_reg);
                op_b = signed'({18'b0, feedback_reg});
                state_next = flanger_pkg::ST_MX1;
            end
            flanger_pkg::ST_MX1:
            begin
                ram_we = 1'b1;
                op_a = OW'(x_reg);
                op_b = OW'(signed'(18'sd32768 - signed'({2'b0, wet_mix_reg})));
                state_next = flanger_pkg::ST_MX2;
            end
            flanger_pkg::ST_MX2:
            begin
                op_a = OW'(delayed_reg);
                op_b = signed'({17'b0, wet_mix_reg});
                if (finish)
                    state_next = flanger_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = flanger_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= flanger_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration, per-channel state and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            delay_span_reg <= 16'd20480;
            feedback_reg   <= '0;
            wet_mix_reg    <= 16'd16384;
            valid_reg      <= '0;
            rvalid_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < flanger_pkg::CHANNELS; i++)
            begin
                phase_reg[i] <= '0;
                wi_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    flanger_pkg::REG_PHASE_STEP: phase_step_reg <= cfg_data;
                    flanger_pkg::REG_DELAY_SPAN: delay_span_reg <= cfg_data[15:0];
                    flanger_pkg::REG_FEEDBACK:   feedback_reg   <= cfg_data[14:0];
                    flanger_pkg::REG_WET_MIX:    wet_mix_reg    <= cfg_data[15:0];
                    default: ;
                endcase
            end
            rvalid_reg <= valid_reg[ram_addr];
            if (ram_we)
                valid_reg[ram_addr] <= 1'b1;
            if (finish)
            begin
                out_valid_reg     <= 1'b1;
                wi_reg[ch_reg]    <= wi_cur + PW'(1);
                phase_reg[ch_reg] <= phase_reg[ch_reg] + {8'b0, phase_step_reg};
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        logic [flanger_pkg::K_W-1:0] k;
        logic [29:0] uraw;
        logic signed [63:0] y, s, dly;
        logic signed [POS_W_T-1:0] pos;
        k    = '0;
        uraw = '0;
        y    = '0;
        s    = '0;
        dly  = '0;
        pos  = '0;
        case (state_reg)
            flanger_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ch_reg   <= s_tuser;
                    x_reg    <= signed'(s_tdata);
                    k        = phase_reg[s_tuser][31 -: flanger_pkg::K_W];
                    uraw     = {k[flanger_pkg::K_W-3:0], (32 - flanger_pkg::K_W)'(0)};
                    quad_reg <= k[flanger_pkg::K_W-1 -: 2];
                    u_reg    <= k[flanger_pkg::K_W-2] ? (31'h40000000 - {1'b0, uraw})
                                                      : {1'b0, uraw};
                end
            end
            flanger_pkg::ST_U2: u2_reg <= 31'(prod >>> 30);
            flanger_pkg::ST_R5: r_reg <= 32'(flanger_pkg::SIN_C5 - (prod >>> 30));
            flanger_pkg::ST_R3: r_reg <= 32'(flanger_pkg::SIN_C3 - (prod >>> 30));
            flanger_pkg::ST_R1: r_reg <= 32'(flanger_pkg::SIN_C1 - (prod >>> 30));
            flanger_pkg::ST_Y:
            begin
                y = prod >>> 30;
                s = (y + 64'sd64) >>> 7;
                if (s > 64'sd8388608)
                    s = 64'sd8388608;
                h_reg <= quad_reg[1] ? 25'(64'sd8388608 - s) : 25'(64'sd8388608 + s);
            end
            flanger_pkg::ST_DLY:
            begin
                dly = 64'sd65536 + (prod >>> 22);
                pos = signed'(POS_W_T'({wi_cur, 16'b0})) - POS_W_T'(dly);
                if (pos < 0)
                    pos = pos + signed'(POS_W_T'({1'b1, (PW + 16)'(0)}));
                idx_reg  <= pos[16 +: PW];
                frac_reg <= pos[15:0];
            end
            flanger_pkg::ST_RDB: a_reg <= tap;
            flanger_pkg::ST_INTA:
            begin
                b_reg   <= tap;
                acc_reg <= prod;
            end
            flanger_pkg::ST_INTB:
                delayed_reg <= 24'((acc_reg + prod + 64'sd32768) >>> 16);
            flanger_pkg::ST_FB:
                back_reg <= flanger_pkg::sat24(64'(x_reg) + ((prod + 64'sd16384) >>> 15));
            flanger_pkg::ST_MX1: acc_reg <= prod;
            flanger_pkg::ST_MX2:
            begin
                if (finish)
                    out_reg <= flanger_pkg::sat24((acc_reg + prod + 64'sd16384) >>> 15);
            end
            default: ;
        endcase
    end

    `FL_ASSERT(a_one_item, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready, "item taken while busy")
    `FL_ASSERT(a_wr_addr, clk, rst_n, ram_we |-> (ram_addr == {ch_reg, wi_cur}), "delay line written at wrong place")
    `FL_ASSERT(a_h_range, clk, rst_n, (state_reg == flanger_pkg::ST_DLY) |-> (h_reg <= 25'h1000000), "lfo offset out of range")
    `FL_ASSERT(a_out_src, clk, rst_n, $rose(m_tvalid) |-> $past(state_reg == flanger_pkg::ST_MX2), "result without mix step")

endmodule

// ===== tb/flanger_fractional_delay_test.sv =====
// ----------------------------------------------------------------------------
// flanger_fractional_delay_test
// self-checking bench for the two-channel flanger: random samples on both
// channels under several register settings, each output item compared with
// an in-bench integer model of the lfo, interpolated delay line and mix
// ----------------------------------------------------------------------------
module flanger_fractional_delay_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint POLY_C1 = 64'sd1686629713;
    localparam longint POLY_C3 = 64'sd693598670;
    localparam longint POLY_C5 = 64'sd85569307;
    localparam longint POLY_C7 = 64'sd5026993;
    localparam int     LINE_LEN = 64;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     STALL_LIMIT = 5000;

    typedef struct packed {
        logic        chan;
        logic [23:0] smp;
    } audio_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    audio_item_t   pending_samples[$];
    logic [23:0]   expected_mix[$];

    // bench copy of the block state and registers
    longint        line_mem[2][LINE_LEN];
    int unsigned   wr_ptr[2];
    bit [31:0]     lfo_acc[2];
    bit [31:0]     step_reg;
    longint        span_reg;
    longint        fb_reg;
    longint        wet_reg;

    int  mismatches = 0;
    int  samples_in = 0;
    int  samples_out = 0;
    int  idle_cycles = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    bit  no_gaps = 1'b0;

    flanger_fractional_delay dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // sample_in [23:0]
        .s_tuser   (s_tuser),    // channel [0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // sample_out [23:0]
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint clip24(longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    // q1.23 sine of the phase quantised to the table resolution
    function automatic longint lfo_sine(bit [31:0] ph);
        bit [1:0] quad;
        longint   u;
        longint   u2;
        longint   r;
        longint   s;
        quad = ph[31:30];
        u = longint'({ph[29:22], 22'd0});
        if (quad[0])
            u = (64'sd1 <<< 30) - u;
        u2 = (u * u) >>> 30;
        r = POLY_C5 - ((u2 * POLY_C7) >>> 30);
        r = POLY_C3 - ((u2 * r) >>> 30);
        r = POLY_C1 - ((u2 * r) >>> 30);
        s = (((u * r) >>> 30) + 64) >>> 7;
        if (s > (64'sd1 <<< 23))
            s = 64'sd1 <<< 23;
        return quad[1] ? -s : s;
    endfunction

    function automatic void flange_sample(logic chan, logic [23:0] smp);
        longint x;
        longint h;
        longint pos;
        longint frac;
        longint delayed;
        int     idx;
        int     wi;
        x = longint'($signed(smp));
        wi = wr_ptr[chan];
        h = lfo_sine(lfo_acc[chan]) + (64'sd1 <<< 23);
        pos = longint'(wi) * 65536 - (65536 + ((span_reg * h) >>> 22));
        while (pos < 0)
            pos += LINE_LEN * 65536;
        idx = int'((pos >>> 16) % LINE_LEN);
        frac = pos & 64'hFFFF;
        delayed = (line_mem[chan][idx] * (65536 - frac)
                   + line_mem[chan][(idx + 1) % LINE_LEN] * frac + 32768) >>> 16;
        line_mem[chan][wi] = clip24(x + ((delayed * fb_reg + 16384) >>> 15));
        expected_mix.push_back(24'(clip24((x * (32768 - wet_reg)
                                           + delayed * wet_reg + 16384) >>> 15)));
        wr_ptr[chan] = (wi + 1) % LINE_LEN;
        lfo_acc[chan] = lfo_acc[chan] + step_reg;
    endfunction

    // mostly back to back, sometimes a short gap, rarely a long wait
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                flange_sample(s_tuser, s_tdata);
                samples_in++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    audio_item_t it;
                    it = pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= it.chan;
                    s_tdata  <= it.smp;
                    in_gap = pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                samples_out++;
                if (expected_mix.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output item %h", m_tdata);
                end
                else
                begin
                    logic [23:0] want;
                    want = expected_mix.pop_front();
                    if (m_tdata !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sample_out item %0d: expected %h, got %h",
                                     samples_out, want, m_tdata);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                out_gap = pick_gap();
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            flanger_pkg::REG_PHASE_STEP: step_reg = {8'd0, val};
            flanger_pkg::REG_DELAY_SPAN: span_reg = longint'(val[15:0]);
            flanger_pkg::REG_FEEDBACK:   fb_reg   = longint'(val[14:0]);
            flanger_pkg::REG_WET_MIX:    wet_reg  = longint'(val[15:0]);
            default: ;
        endcase
    endtask

    // upper bits above each register width are set at random to check they drop
    task automatic set_all(logic [23:0] stp, logic [15:0] spn, logic [14:0] fb,
                           logic [15:0] wet);
        write_reg(flanger_pkg::REG_PHASE_STEP, stp);
        write_reg(flanger_pkg::REG_DELAY_SPAN, {8'($urandom), spn});
        write_reg(flanger_pkg::REG_FEEDBACK, {8'($urandom), $urandom_range(0, 1) == 1, fb});
        write_reg(flanger_pkg::REG_WET_MIX, {8'($urandom), wet});
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_samples.size() > 0 || expected_mix.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(int n);
        audio_item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.chan = 1'($urandom);
            case ($urandom_range(0, 9))
                0:       it.smp = 24'h7FFFFF;
                1:       it.smp = 24'h800000;
                2:       it.smp = 24'($urandom_range(0, 15)) - 24'd8;
                default: it.smp = 24'($urandom);
            endcase
            pending_samples.push_back(it);
        end
    endtask

    initial
    begin
        audio_item_t it;
        logic [23:0] edge_vals[6];
        foreach (line_mem[c, j])
            line_mem[c][j] = 0;
        wr_ptr = '{0, 0};
        lfo_acc = '{0, 0};
        step_reg = 0;
        span_reg = 20480;
        fb_reg = 0;
        wet_reg = 16384;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings first, then full-scale and small values on both channels
        edge_vals = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001,
                      24'h555555};
        no_gaps = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            it.chan = i[0];
            it.smp  = edge_vals[i % 6];
            pending_samples.push_back(it);
        end
        wait_drained();
        no_gaps = 1'b0;

        // register extremes: wet above one, depth above range, feedback at 26214
        set_all(24'hFFFFFF, 16'hFFFF, 15'd26214, 16'hFFFF);
        for (int i = 0; i < 8; i++)
        begin
            it.chan = i[1];
            it.smp  = edge_vals[i % 2];
            pending_samples.push_back(it);
        end
        wait_drained();
        set_all(24'd0, 16'd0, 15'h7FFF, 16'd0);
        queue_random(6);
        wait_drained();
        set_all(24'd4096, 16'd40960, 15'd0, 16'd32768);
        queue_random(60);
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            no_gaps = (ph == 3);
            set_all(24'($urandom), 16'($urandom_range(0, 40960)),
                    15'($urandom_range(0, 26214)), 16'($urandom_range(0, 32768)));
            queue_random(55);
            wait_drained();
        end

        while (expected_mix.size() > 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("missing output item, expected %h", expected_mix[0]);
            void'(expected_mix.pop_front());
        end
        $display("%0d samples sent, %0d mixed samples checked over 12 register settings",
                 samples_in, samples_out);
        $display("%0d mismatches counted", mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
